// File: rtl/ptl_pkg.sv
package ptl_pkg;

	// lexer modes
	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_COMMENT = 4'd1,
		M_INT     = 4'd2,
		M_INT_DOT = 4'd3,
		M_REAL    = 4'd4,
		M_EXPS_I  = 4'd5,
		M_EXPS_R  = 4'd6,
		M_EXPD_I  = 4'd7,
		M_EXPD_R  = 4'd8,
		M_WORD    = 4'd9,
		M_SYMBOL  = 4'd10,
		M_QSTR    = 4'd11,
		M_QESC    = 4'd12,
		M_QDEC    = 4'd13
	} lex_mode_t;

	// character classes
	typedef enum logic [2:0] {
		C_ILL = 3'd0,
		C_WS  = 3'd1,
		C_PUN = 3'd2,
		C_STR = 3'd3,
		C_SYM = 3'd4,
		C_QUO = 3'd5,
		C_DIG = 3'd6,
		C_WRD = 3'd7
	} cls_t;

	// token kinds
	localparam logic [2:0] K_INT    = 3'd0;
	localparam logic [2:0] K_REAL   = 3'd1;
	localparam logic [2:0] K_WORD   = 3'd2;
	localparam logic [2:0] K_QUOTED = 3'd3;
	localparam logic [2:0] K_STRING = 3'd4;
	localparam logic [2:0] K_SYMBOL = 3'd5;
	localparam logic [2:0] K_PUNCT  = 3'd6;
	localparam logic [2:0] K_EOF    = 3'd7;

	// error codes
	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_ILLEGAL = 2'd1;
	localparam logic [1:0] E_BIGESC  = 2'd2;
	localparam logic [1:0] E_OPENSTR = 2'd3;

	localparam logic [9:0]  MAX_TOKEN = 10'd511;
	localparam logic [30:0] INT_MAX   = 31'h7FFF_FFFF;
	localparam logic [23:0] LINE_MAX  = 24'hFF_FFFF;
	localparam logic [7:0]  ESC_SAT   = 8'd255;
	localparam logic [7:0]  ESC_MAX   = 8'd127;
	localparam int          NUM_RES   = 4;

	// characters
	localparam logic [6:0] CH_NUL   = 7'h00;
	localparam logic [6:0] CH_EOT   = 7'h04;
	localparam logic [6:0] CH_BEL   = 7'h07;
	localparam logic [6:0] CH_TAB   = 7'h09;
	localparam logic [6:0] CH_NL    = 7'h0A;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_BANG  = 7'h21;
	localparam logic [6:0] CH_DQ    = 7'h22;
	localparam logic [6:0] CH_PCT   = 7'h25;
	localparam logic [6:0] CH_SQ    = 7'h27;
	localparam logic [6:0] CH_LPAR  = 7'h28;
	localparam logic [6:0] CH_RPAR  = 7'h29;
	localparam logic [6:0] CH_COMMA = 7'h2C;
	localparam logic [6:0] CH_DOT   = 7'h2E;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_NINE  = 7'h39;
	localparam logic [6:0] CH_SEMI  = 7'h3B;
	localparam logic [6:0] CH_UA    = 7'h41;
	localparam logic [6:0] CH_UE    = 7'h45;
	localparam logic [6:0] CH_UZ    = 7'h5A;
	localparam logic [6:0] CH_LBRK  = 7'h5B;
	localparam logic [6:0] CH_BSL   = 7'h5C;
	localparam logic [6:0] CH_RBRK  = 7'h5D;
	localparam logic [6:0] CH_USC   = 7'h5F;
	localparam logic [6:0] CH_LA    = 7'h61;
	localparam logic [6:0] CH_LB    = 7'h62;
	localparam logic [6:0] CH_LE    = 7'h65;
	localparam logic [6:0] CH_LN    = 7'h6E;
	localparam logic [6:0] CH_LT    = 7'h74;
	localparam logic [6:0] CH_LZ    = 7'h7A;
	localparam logic [6:0] CH_LBRC  = 7'h7B;
	localparam logic [6:0] CH_RBRC  = 7'h7D;
	localparam logic [6:0] CH_DEL   = 7'h7F;

	typedef struct packed {
		lex_mode_t   mode;
		logic [9:0]  tlen;
		logic [30:0] iacc;
		logic        cdq;
		logic        qf;
		logic [7:0]  eacc;
		logic [23:0] line;
	} lex_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [6:0]  tok_byte;
		logic        byte_valid;
		logic        token_last;
		logic [30:0] int_value;
		logic        needs_quote;
		logic [1:0]  err;
	} res_t;

	typedef struct packed {
		lex_state_t     st;
		logic           again;
		logic [1:0]     n;
		res_t [1:0]     res;
	} step_t;

	typedef struct packed {
		lex_state_t st;
		logic       emit;
		res_t       res;
	} put_t;

	// all results of one transaction
	typedef struct packed {
		res_t [NUM_RES-1:0] res;
		logic [2:0]         n;
	} batch_t;

	function automatic cls_t char_class(logic [6:0] c);
		cls_t cl;
		if (c >= CH_ZERO && c <= CH_NINE) cl = C_DIG;
		else if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) || c == CH_USC)
			cl = C_WRD;
		else if (c == CH_NUL || c == CH_NL || c == CH_SPACE) cl = C_WS;
		else if (c == CH_EOT || c == CH_BANG || c == CH_LPAR || c == CH_RPAR ||
			c == CH_COMMA || c == CH_SEMI || c == CH_LBRK || c == CH_RBRK ||
			c == CH_LBRC || c == CH_RBRC || c == CH_DEL) cl = C_PUN;
		else if (c == CH_DQ) cl = C_STR;
		else if (c == CH_SQ) cl = C_QUO;
		else if (c < CH_SPACE) cl = C_ILL;
		else cl = C_SYM;
		return cl;
	endfunction

	function automatic res_t mk_res(logic [2:0] kind, logic [6:0] b, logic v, logic last,
		logic [30:0] ival, logic nq, logic [1:0] err);
		res_t r;
		r.kind        = kind;
		r.tok_byte    = b;
		r.byte_valid  = v;
		r.token_last  = last;
		r.int_value   = ival;
		r.needs_quote = nq;
		r.err         = err;
		return r;
	endfunction

	// saturating decimal accumulate
	function automatic logic [30:0] add_digit(logic [30:0] acc, logic [3:0] d);
		logic [34:0] v;
		v = 35'(acc) * 35'd10 + 35'(d);
		return (v > 35'(INT_MAX)) ? INT_MAX : v[30:0];
	endfunction

	// store one token byte, subject to the length limit
	function automatic put_t put_byte(lex_state_t s, logic [2:0] kind, logic [6:0] c,
		logic [1:0] err);
		put_t p;
		cls_t cl;
		cl     = char_class(c);
		p.st   = s;
		p.emit = 1'b0;
		p.res  = mk_res(kind, c, 1'b1, 1'b0, '0, 1'b0, err);
		if (s.tlen < MAX_TOKEN) begin
			if (s.tlen == '0) p.st.qf = !(c >= CH_LA && c <= CH_LZ);
			else if (cl != C_WRD && cl != C_DIG) p.st.qf = 1'b1;
			p.st.tlen = s.tlen + 10'd1;
			p.emit    = 1'b1;
		end else if (err != E_NONE) begin
			p.emit = 1'b1;
			p.res  = mk_res(kind, '0, 1'b0, 1'b0, '0, 1'b0, err);
		end
		return p;
	endfunction

	function automatic step_t push(step_t t, res_t r);
		step_t o;
		o = t;
		o.res[t.n[0]] = r;
		o.n = t.n + 2'd1;
		return o;
	endfunction

	function automatic step_t push_put(step_t t, put_t p);
		step_t o;
		o = t;
		o.st = p.st;
		if (p.emit) o = push(o, p.res);
		return o;
	endfunction

	function automatic res_t finish_res(lex_state_t s, logic [2:0] kind, logic [1:0] err);
		return mk_res(kind, '0, 1'b0, 1'b1, (kind == K_INT) ? s.iacc : '0,
			(kind >= K_WORD && kind <= K_PUNCT) ? s.qf : 1'b0, err);
	endfunction

	function automatic lex_state_t start_token(lex_state_t s, lex_mode_t m);
		lex_state_t o;
		o      = s;
		o.mode = m;
		o.tlen = '0;
		o.qf   = 1'b1;
		o.iacc = '0;
		o.eacc = '0;
		return o;
	endfunction

	// one pass of the lexer over a character in the current mode
	function automatic step_t lex_step(lex_state_t s, logic [6:0] c, logic eoi);
		step_t      t;
		cls_t       cl;
		logic [2:0] qk;
		logic [2:0] k;
		logic [3:0] d;
		logic [11:0] v;
		lex_state_t f;
		cl      = char_class(c);
		qk      = s.cdq ? K_STRING : K_QUOTED;
		d       = 4'(c - CH_ZERO);
		v       = 12'(s.eacc) * 12'd10 + 12'(d);
		t.st    = s;
		t.again = 1'b0;
		t.n     = '0;
		t.res   = '0;
		k       = (s.mode == M_EXPS_R || s.mode == M_EXPD_R) ? K_REAL : K_INT;
		f       = s;
		f.mode  = M_IDLE;
		case (s.mode)
			M_COMMENT: begin
				if (eoi) begin
					t.st.mode = M_IDLE;
					t.again   = 1'b1;
				end else if (c == CH_NL) begin
					if (s.line < LINE_MAX) t.st.line = s.line + 24'd1;
					t.st.mode = M_IDLE;
				end
			end
			M_INT: begin
				if (eoi || !(cl == C_DIG || c == CH_DOT || c == CH_LE || c == CH_UE)) begin
					t       = push(t, finish_res(s, K_INT, E_NONE));
					t.st    = f;
					t.again = 1'b1;
				end else if (cl == C_DIG) begin
					t.st.iacc = add_digit(s.iacc, d);
					t = push_put(t, put_byte(t.st, K_INT, c, E_NONE));
				end else if (c == CH_DOT) begin
					t.st.mode = M_INT_DOT;
				end else begin
					t = push_put(t, put_byte(s, K_INT, c, E_NONE));
					t.st.mode = M_EXPS_I;
				end
			end
			M_INT_DOT: begin
				if (!eoi && cl == C_DIG) begin
					t = push_put(t, put_byte(s, K_REAL, CH_DOT, E_NONE));
					t = push_put(t, put_byte(t.st, K_REAL, c, E_NONE));
					t.st.mode = M_REAL;
				end else begin
					// integer ends; the dot opens a symbol run
					t = push(t, finish_res(s, K_INT, E_NONE));
					t = push_put(t, put_byte(start_token(s, M_SYMBOL), K_SYMBOL, CH_DOT,
						E_NONE));
					t.again = 1'b1;
				end
			end
			M_REAL: begin
				if (eoi || !(cl == C_DIG || c == CH_LE || c == CH_UE)) begin
					t       = push(t, finish_res(s, K_REAL, E_NONE));
					t.st    = f;
					t.again = 1'b1;
				end else if (cl == C_DIG) begin
					t = push_put(t, put_byte(s, K_REAL, c, E_NONE));
				end else begin
					t = push_put(t, put_byte(s, K_REAL, c, E_NONE));
					t.st.mode = M_EXPS_R;
				end
			end
			M_EXPS_I, M_EXPS_R: begin
				if (eoi) begin
					t       = push(t, finish_res(s, k, E_NONE));
					t.st    = f;
					t.again = 1'b1;
				end else begin
					t = push_put(t, put_byte(s, k, c, E_NONE));
					t.st.mode = (k == K_REAL) ? M_EXPD_R : M_EXPD_I;
				end
			end
			M_EXPD_I, M_EXPD_R: begin
				if (!eoi && cl == C_DIG) begin
					t = push_put(t, put_byte(s, k, c, E_NONE));
				end else begin
					t       = push(t, finish_res(s, k, E_NONE));
					t.st    = f;
					t.again = 1'b1;
				end
			end
			M_WORD: begin
				if (!eoi && (cl == C_WRD || cl == C_DIG)) begin
					t = push_put(t, put_byte(s, K_WORD, c, E_NONE));
				end else begin
					t       = push(t, finish_res(s, K_WORD, E_NONE));
					t.st    = f;
					t.again = 1'b1;
				end
			end
			M_SYMBOL: begin
				if (!eoi && cl == C_SYM) begin
					t = push_put(t, put_byte(s, K_SYMBOL, c, E_NONE));
				end else begin
					t       = push(t, finish_res(s, K_SYMBOL, E_NONE));
					t.st    = f;
					t.again = 1'b1;
				end
			end
			M_QSTR: begin
				if (eoi) begin
					t       = push(t, finish_res(s, qk, E_OPENSTR));
					t.st    = f;
					t.again = 1'b1;
				end else if ((s.cdq && c == CH_DQ) || (!s.cdq && c == CH_SQ)) begin
					t    = push(t, finish_res(s, qk, E_NONE));
					t.st = f;
				end else if (c == CH_BSL) begin
					t.st.mode = M_QESC;
				end else begin
					t = push_put(t, put_byte(s, qk, c, E_NONE));
				end
			end
			M_QESC: begin
				if (eoi) begin
					t       = push(t, finish_res(s, qk, E_OPENSTR));
					t.st    = f;
					t.again = 1'b1;
				end else if (c == CH_LB) begin
					t = push_put(t, put_byte(s, qk, CH_BEL, E_NONE));
					t.st.mode = M_QSTR;
				end else if (c == CH_LN) begin
					t = push_put(t, put_byte(s, qk, CH_NL, E_NONE));
					t.st.mode = M_QSTR;
				end else if (c == CH_LT) begin
					t = push_put(t, put_byte(s, qk, CH_TAB, E_NONE));
					t.st.mode = M_QSTR;
				end else if (cl == C_DIG) begin
					t.st.eacc = 8'(d);
					t.st.mode = M_QDEC;
				end else begin
					t = push_put(t, put_byte(s, qk, c, E_NONE));
					t.st.mode = M_QSTR;
				end
			end
			M_QDEC: begin
				if (!eoi && cl == C_DIG) begin
					t.st.eacc = (v > 12'(ESC_SAT)) ? ESC_SAT : v[7:0];
				end else begin
					// range test on the saturated value, before the cut to 7 bits
					if (s.eacc > ESC_MAX) t = push_put(t, put_byte(s, qk, CH_DEL, E_BIGESC));
					else t = push_put(t, put_byte(s, qk, s.eacc[6:0], E_NONE));
					t.st.mode = M_QSTR;
					t.again   = 1'b1;
				end
			end
			default: begin
				t.st.mode = M_IDLE;
				if (eoi) begin
					t = push(t, mk_res(K_EOF, '0, 1'b0, 1'b1, '0, 1'b0, E_NONE));
				end else if (c == CH_SPACE || c == CH_TAB) begin
					t.st.mode = M_IDLE;
				end else if (c == CH_NL) begin
					if (s.line < LINE_MAX) t.st.line = s.line + 24'd1;
				end else if (c == CH_PCT) begin
					t.st.mode = M_COMMENT;
				end else begin
					case (cl)
						C_DIG: begin
							t.st      = start_token(s, M_INT);
							t.st.iacc = add_digit('0, d);
							t = push_put(t, put_byte(t.st, K_INT, c, E_NONE));
						end
						C_WRD: t = push_put(t, put_byte(start_token(s, M_WORD), K_WORD, c,
							E_NONE));
						C_SYM: t = push_put(t, put_byte(start_token(s, M_SYMBOL), K_SYMBOL,
							c, E_NONE));
						C_QUO, C_STR: begin
							t.st     = start_token(s, M_QSTR);
							t.st.cdq = (cl == C_STR);
						end
						C_PUN: begin
							t.st      = start_token(s, M_IDLE);
							t.st.tlen = 10'd1;
							t = push(t, mk_res(K_PUNCT, c, 1'b1, 1'b1, '0, 1'b1, E_NONE));
						end
						default: t = push(t, mk_res(K_PUNCT, c, 1'b0, 1'b1, '0, 1'b0,
							E_ILLEGAL));
					endcase
				end
			end
		endcase
		return t;
	endfunction

endpackage

// File: rtl/prolog_token_lexer.sv
// channel  signals                                    direction
// in       in_valid, in_ready, ch, end_of_input       to block
// out      out_valid, out_ready, kind, tok_byte,      from block
//          byte_valid, token_last, int_value,
//          needs_quote, err, line_number
// A character waits in the input register until the queue has room, then all of its
// results (zero to four) are loaded at once into a four-slot result queue.
// The queue drains one result per cycle while out_ready is high; the next
// character is loaded as the last result leaves.
// Reset clears the lexer state, the line count and both valid flags.
module prolog_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  ch,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [6:0]  tok_byte,
	output logic        byte_valid,
	output logic        token_last,
	output logic [30:0] int_value,
	output logic        needs_quote,
	output logic [1:0]  err,
	output logic [23:0] line_number
);
	import ptl_pkg::*;

	logic       valid_s1;
	logic [6:0] ch_s1;
	logic       eoi_s1;
	logic       room;
	logic       load;
	batch_t     batch;
	res_t       head;

	assign load     = valid_s1 && room;
	assign in_ready = !valid_s1 || load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1  <= ch;
			eoi_s1 <= end_of_input;
		end
	end

	ptl_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.ch          (ch_s1),
		.eoi         (eoi_s1),
		.batch       (batch),
		.line_number (line_number)
	);

	ptl_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.batch     (batch),
		.pop       (out_ready),
		.room      (room),
		.out_valid (out_valid),
		.head      (head)
	);

	assign kind        = head.kind;
	assign tok_byte    = head.tok_byte;
	assign byte_valid  = head.byte_valid;
	assign token_last  = head.token_last;
	assign int_value   = head.int_value;
	assign needs_quote = head.needs_quote;
	assign err         = head.err;

`ifndef SYNTHESIS
	// a held character is never dropped before it is processed
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load) |=> valid_s1) else $error("input item lost");
	// one character never yields more than four results
	a_batch_n: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (batch.n <= 3'd4)) else $error("too many results");
	// end-of-file results always close a token
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == K_EOF) |-> token_last) else $error("open end-of-file");
`endif

endmodule

// File: rtl/ptl_step.sv
module ptl_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [6:0]      ch,
	input  logic            eoi,
	output ptl_pkg::batch_t batch,
	output logic [23:0]     line_number
);
	import ptl_pkg::*;

	lex_state_t  state_q;
	lex_state_t  state_d;
	logic [23:0] line_q;

	// up to four passes over the held character
	always_comb begin
		lex_state_t s;
		step_t      t;
		logic       go;
		s     = state_q;
		t     = '0;
		go    = 1'b1;
		batch = '0;
		for (int i = 0; i < NUM_RES; i++) begin
			if (go) begin
				t = lex_step(s, ch, eoi);
				for (int j = 0; j < 2; j++) begin
					if (2'(j) < t.n && batch.n < 3'(NUM_RES)) begin
						batch.res[batch.n[1:0]] = t.res[j];
						batch.n = batch.n + 3'd1;
					end
				end
				s  = t.st;
				go = t.again;
			end
		end
		state_d = s;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load) begin
			state_q <= state_d;
		end
	end

	// a newline is always the last pass of a transaction, so every result of
	// a batch carries the line count from before that transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (load) begin
			line_q <= state_q.line;
		end
	end

	assign line_number = line_q;

endmodule

// File: rtl/ptl_outbuf.sv
module ptl_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ptl_pkg::batch_t batch,
	input  logic            pop,
	output logic            room,
	output logic            out_valid,
	output ptl_pkg::res_t   head
);
	import ptl_pkg::*;

	res_t [NUM_RES-1:0] buf_q;
	logic [2:0]         cnt_q;
	logic               take;

	assign out_valid = (cnt_q != '0);
	assign take      = pop && out_valid;
	// the next batch may enter when the last queued result leaves
	assign room      = (cnt_q == '0) || (cnt_q == 3'd1 && take);
	assign head      = buf_q[0];

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.n;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// result slots, head at index 0
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= batch.res;
		end else if (take) begin
			for (int i = 0; i < NUM_RES - 1; i++) buf_q[i] <= buf_q[i+1];
		end
	end

endmodule

// File: dv/tb_top.sv
module tb_top;
	import ptl_pkg::*;

	// one expected token result, with the line count it carries
	typedef struct {
		bit [2:0]  kind;
		bit [6:0]  tok_byte;
		bit        byte_valid;
		bit        token_last;
		bit [30:0] int_value;
		bit        needs_quote;
		bit [1:0]  err;
		bit [23:0] line_number;
	} tok_res_t;

	// token predictor and store of expected results
	class lexer_scoreboard;
		lex_mode_t mode;
		int        tlen;
		bit [30:0] iacc;
		bit        cdq;
		bit        qf;
		int        eacc;
		bit [23:0] lines;
		int        n_step;
		int        errors;
		tok_res_t  expected_q[$];

		function new();
			mode   = M_IDLE;
			tlen   = 0;
			iacc   = '0;
			cdq    = 0;
			qf     = 0;
			eacc   = 0;
			lines  = '0;
			errors = 0;
		endfunction

		function cls_t classify(bit [6:0] c);
			if (c >= "0" && c <= "9") return C_DIG;
			if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") return C_WRD;
			if (c == 0 || c == 10 || c == 32) return C_WS;
			if (c == 4 || c == "!" || c == "(" || c == ")" || c == "," || c == ";" ||
				c == "[" || c == "]" || c == "{" || c == "}" || c == 127) return C_PUN;
			if (c == "\"") return C_STR;
			if (c == "'") return C_QUO;
			if (c < 32) return C_ILL;
			return C_SYM;
		endfunction

		function void push_res(bit [2:0] k, bit [6:0] b, bit v, bit last, bit [30:0] iv,
			bit nq, bit [1:0] e);
			tok_res_t r;
			if (n_step >= NUM_RES) return;
			r.kind        = k;
			r.tok_byte    = b;
			r.byte_valid  = v;
			r.token_last  = last;
			r.int_value   = iv;
			r.needs_quote = nq;
			r.err         = e;
			r.line_number = lines;
			expected_q.push_back(r);
			n_step++;
		endfunction

		function void bump_line();
			if (lines != LINE_MAX) lines++;
		endfunction

		function void open_tok(lex_mode_t m);
			mode = m;
			tlen = 0;
			qf   = 1;
			iacc = '0;
			eacc = 0;
		endfunction

		// store one token byte; past the limit only an error still shows
		function void store(bit [2:0] k, bit [6:0] c, bit [1:0] e);
			cls_t cl;
			cl = classify(c);
			if (tlen < MAX_TOKEN) begin
				if (tlen == 0) qf = !(c >= "a" && c <= "z");
				else if (cl != C_WRD && cl != C_DIG) qf = 1;
				tlen++;
				push_res(k, c, 1, 0, '0, 0, e);
			end else if (e != E_NONE) begin
				push_res(k, '0, 0, 0, '0, 0, e);
			end
		endfunction

		function void close_tok(bit [2:0] k, bit [1:0] e);
			push_res(k, '0, 0, 1, (k == K_INT) ? iacc : 31'd0,
				(k >= K_WORD && k <= K_PUNCT) ? qf : 1'b0, e);
			mode = M_IDLE;
		endfunction

		function void accum(int d);
			longint unsigned v;
			v = longint'(iacc) * 10 + d;
			iacc = (v > INT_MAX) ? INT_MAX : v[30:0];
		endfunction

		// one pass over a character; returns 1 if it must be seen again
		function bit handle(bit [6:0] c, bit eoi);
			cls_t     cl;
			bit [2:0] qk;
			bit [2:0] k;
			int       d;
			cl = classify(c);
			qk = cdq ? K_STRING : K_QUOTED;
			k  = (mode == M_EXPS_R || mode == M_EXPD_R) ? K_REAL : K_INT;
			d  = int'(c) - 48;
			case (mode)
				M_COMMENT: begin
					if (eoi) begin
						mode = M_IDLE;
						return 1;
					end
					if (c == 10) begin
						bump_line();
						mode = M_IDLE;
					end
					return 0;
				end
				M_INT: begin
					if (eoi) begin
						close_tok(K_INT, E_NONE);
						return 1;
					end
					if (cl == C_DIG) begin
						accum(d);
						store(K_INT, c, E_NONE);
					end else if (c == ".") mode = M_INT_DOT;
					else if (c == "e" || c == "E") begin
						store(K_INT, c, E_NONE);
						mode = M_EXPS_I;
					end else begin
						close_tok(K_INT, E_NONE);
						return 1;
					end
					return 0;
				end
				M_INT_DOT: begin
					if (!eoi && cl == C_DIG) begin
						store(K_REAL, 7'("."), E_NONE);
						store(K_REAL, c, E_NONE);
						mode = M_REAL;
						return 0;
					end
					// integer closes, the dot opens a symbol run
					close_tok(K_INT, E_NONE);
					open_tok(M_SYMBOL);
					store(K_SYMBOL, 7'("."), E_NONE);
					return 1;
				end
				M_REAL: begin
					if (eoi) begin
						close_tok(K_REAL, E_NONE);
						return 1;
					end
					if (cl == C_DIG) store(K_REAL, c, E_NONE);
					else if (c == "e" || c == "E") begin
						store(K_REAL, c, E_NONE);
						mode = M_EXPS_R;
					end else begin
						close_tok(K_REAL, E_NONE);
						return 1;
					end
					return 0;
				end
				M_EXPS_I, M_EXPS_R: begin
					if (eoi) begin
						close_tok(k, E_NONE);
						return 1;
					end
					store(k, c, E_NONE);
					mode = (k == K_REAL) ? M_EXPD_R : M_EXPD_I;
					return 0;
				end
				M_EXPD_I, M_EXPD_R: begin
					if (!eoi && cl == C_DIG) begin
						store(k, c, E_NONE);
						return 0;
					end
					close_tok(k, E_NONE);
					return 1;
				end
				M_WORD: begin
					if (!eoi && (cl == C_WRD || cl == C_DIG)) begin
						store(K_WORD, c, E_NONE);
						return 0;
					end
					close_tok(K_WORD, E_NONE);
					return 1;
				end
				M_SYMBOL: begin
					if (!eoi && cl == C_SYM) begin
						store(K_SYMBOL, c, E_NONE);
						return 0;
					end
					close_tok(K_SYMBOL, E_NONE);
					return 1;
				end
				M_QSTR: begin
					if (eoi) begin
						close_tok(qk, E_OPENSTR);
						return 1;
					end
					if ((cdq && c == "\"") || (!cdq && c == "'")) close_tok(qk, E_NONE);
					else if (c == "\\") mode = M_QESC;
					else store(qk, c, E_NONE);
					return 0;
				end
				M_QESC: begin
					if (eoi) begin
						close_tok(qk, E_OPENSTR);
						return 1;
					end
					mode = M_QSTR;
					if (c == "b") store(qk, 7, E_NONE);
					else if (c == "n") store(qk, 10, E_NONE);
					else if (c == "t") store(qk, 9, E_NONE);
					else if (cl == C_DIG) begin
						eacc = d;
						mode = M_QDEC;
					end else store(qk, c, E_NONE);
					return 0;
				end
				M_QDEC: begin
					if (!eoi && cl == C_DIG) begin
						eacc = eacc * 10 + d;
						if (eacc > 255) eacc = 255;
						return 0;
					end
					if (eacc > 127) store(qk, 127, E_BIGESC);
					else store(qk, eacc[6:0], E_NONE);
					mode = M_QSTR;
					return 1;
				end
				default: ;
			endcase
			// between tokens
			mode = M_IDLE;
			if (eoi) begin
				push_res(K_EOF, '0, 0, 1, '0, 0, E_NONE);
				return 0;
			end
			if (c == " " || c == 9) return 0;
			if (c == 10) begin
				bump_line();
				return 0;
			end
			if (c == "%") begin
				mode = M_COMMENT;
				return 0;
			end
			case (cl)
				C_DIG: begin
					open_tok(M_INT);
					accum(d);
					store(K_INT, c, E_NONE);
				end
				C_WRD: begin
					open_tok(M_WORD);
					store(K_WORD, c, E_NONE);
				end
				C_SYM: begin
					open_tok(M_SYMBOL);
					store(K_SYMBOL, c, E_NONE);
				end
				C_QUO, C_STR: begin
					open_tok(M_QSTR);
					cdq = (cl == C_STR);
				end
				C_PUN: begin
					open_tok(M_IDLE);
					tlen = 1;
					push_res(K_PUNCT, c, 1, 1, '0, 1, E_NONE);
				end
				default: push_res(K_PUNCT, c, 0, 1, '0, 0, E_ILLEGAL);
			endcase
			return 0;
		endfunction

		// accepted input transaction
		function void note_char(bit [6:0] c, bit eoi);
			n_step = 0;
			for (int i = 0; i < 4; i++)
				if (!handle(c, eoi)) break;
		endfunction

		task report(string msg);
			$display("ERROR %0t: %s", $realtime, msg);
			errors++;
		endtask

		// accepted output transaction
		task check_res(tok_res_t got);
			tok_res_t w;
			if (expected_q.size() == 0) begin
				report("result with no expected result");
				return;
			end
			w = expected_q.pop_front();
			if (got.kind != w.kind)
				report($sformatf("kind %0d, expected %0d", got.kind, w.kind));
			if (got.tok_byte != w.tok_byte)
				report($sformatf("tok_byte %0h, expected %0h", got.tok_byte, w.tok_byte));
			if (got.byte_valid != w.byte_valid)
				report($sformatf("byte_valid %0d, expected %0d", got.byte_valid,
					w.byte_valid));
			if (got.token_last != w.token_last)
				report($sformatf("token_last %0d, expected %0d", got.token_last,
					w.token_last));
			if (got.int_value != w.int_value)
				report($sformatf("int_value %0d, expected %0d", got.int_value, w.int_value));
			if (got.needs_quote != w.needs_quote)
				report($sformatf("needs_quote %0d, expected %0d", got.needs_quote,
					w.needs_quote));
			if (got.err != w.err)
				report($sformatf("err %0d, expected %0d", got.err, w.err));
			if (got.line_number != w.line_number)
				report($sformatf("line_number %0d, expected %0d", got.line_number,
					w.line_number));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [6:0]  ch = '0;
	logic        end_of_input = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  kind;
	logic [6:0]  tok_byte;
	logic        byte_valid;
	logic        token_last;
	logic [30:0] int_value;
	logic        needs_quote;
	logic [1:0]  err;
	logic [23:0] line_number;

	lexer_scoreboard sb = new();
	int  chars_sent = 0;
	bit  in_calm = 0;
	bit  out_calm = 0;
	bit  took = 0;
	int  stall = 0;

	prolog_token_lexer DUT (.*);

	always #5 clk = ~clk;

	// output monitor: fields are stable at the falling edge before acceptance
	always @(negedge clk) begin
		tok_res_t g;
		took = 0;
		if (arst_n && out_valid && out_ready) begin
			g.kind        = kind;
			g.tok_byte    = tok_byte;
			g.byte_valid  = byte_valid;
			g.token_last  = token_last;
			g.int_value   = int_value;
			g.needs_quote = needs_quote;
			g.err         = err;
			g.line_number = line_number;
			sb.check_res(g);
			took = 1;
		end
	end

	// receiver stalls, with quiet stretches
	always @(posedge clk) begin
		int w;
		if (arst_n) begin
			if ($urandom_range(0, 60) == 0) out_calm = !out_calm;
			if (took) begin
				w = out_calm ? 0 : $urandom_range(0, 5);
				stall     <= w;
				out_ready <= (w == 0);
			end else if (stall > 0) begin
				stall     <= stall - 1;
				out_ready <= (stall == 1);
			end else out_ready <= 1;
		end
	end

	// one input transaction, after a random gap
	task automatic send_char(input logic [6:0] c, input logic eoi);
		int gap;
		if ($urandom_range(0, 60) == 0) in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1;
		ch           <= c;
		end_of_input <= eoi;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.note_char(c, eoi);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(7'(s.getc(i)), 0);
	endtask

	task automatic send_digits(input int n);
		repeat (n) send_char(7'($urandom_range("0", "9")), 0);
	endtask

	function automatic logic [6:0] pick(input string s);
		return 7'(s.getc($urandom_range(0, s.len() - 1)));
	endfunction

	// one random token or piece of noise
	task automatic send_random_token();
		string sym_chars = "+-*/\\^<>=~:.?@#&$`|";
		string word_chars = "abcxyzAQZ_09eE";
		string pun_chars = "!(),;[]{}";
		int sel;
		sel = $urandom_range(0, 13);
		case (sel)
			0: send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
				: $urandom_range(1, 4));
			1: begin
				send_digits($urandom_range(1, 3));
				send_char(7'("."), 0);
				send_digits($urandom_range(0, 3));
				if ($urandom_range(0, 1)) begin
					send_char(pick("eE"), 0);
					send_char(pick("+-5x"), 0);
					send_digits($urandom_range(0, 2));
				end
			end
			2: begin
				send_digits($urandom_range(1, 3));
				send_char(pick("eE"), 0);
				send_char(7'($urandom_range(0, 127)), 0);
				send_digits($urandom_range(0, 2));
			end
			3: begin
				send_char(pick("aqzAZ_"), 0);
				repeat ($urandom_range(0, 6)) send_char(pick(word_chars), 0);
			end
			4: repeat ($urandom_range(1, 4)) send_char(pick(sym_chars), 0);
			5, 6: begin
				logic [6:0] q;
				q = $urandom_range(0, 1) ? 7'("\"") : 7'("'");
				send_char(q, 0);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 3) == 0) begin
						send_char(7'("\\"), 0);
						if ($urandom_range(0, 1)) send_char(pick("bntz\\'\""), 0);
						else send_digits($urandom_range(1, 4));
					end else send_char(7'($urandom_range(32, 126)), 0);
				end
				send_char(q, 0);
			end
			7: send_char(pick(pun_chars), 0);
			8: send_char(pick(" \t\n"), 0);
			9: begin
				send_char(7'("%"), 0);
				repeat ($urandom_range(0, 4)) send_char(7'($urandom_range(0, 127)), 0);
				send_char(10, 0);
			end
			10, 11: send_char(7'($urandom_range(0, 127)), 0);
			12: if ($urandom_range(0, 3) == 0) send_char(7'($urandom_range(0, 127)), 1);
			default: send_char(7'(" "), 0);
		endcase
		if ($urandom_range(0, 2) != 0) send_char(pick(" \n"), 0);
	endtask

	// stimulus
	initial begin
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: numbers, saturation, dot cases, quoting, escapes, illegal chars
		send_text("ab X9 007.5e+3 1.x 99999999999 +-* ");
		send_text("'a\\n\\t\\b\\65\\200\\q' \"s\\");
		send_char(0, 1);
		send_text("! % note\n");
		send_char(1, 0);
		send_char(0, 0);
		send_char(127, 0);
		send_char(4, 0);
		send_text("\"open");
		send_char(0, 1);
		send_text("%c");
		send_char(0, 1);

		// random text
		while (chars_sent < 360) send_random_token();
		send_char(0, 1);
		in_valid <= 0;

		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	// hard limit
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
